// ===== sv/acr_pkg.sv =====
// Shared constants, types and helpers for the block autocorrelation engine.
// No dependencies; imported by acr_cell and block_autocorrelation.
`default_nettype none

package acr_pkg;

    localparam int MAX_LAGS  = 16;
    localparam int MAX_OUT   = (MAX_LAGS < 16) ? MAX_LAGS : 16;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = 48;
    localparam int NLAGS_W   = 5;
    localparam int IDX_W     = 4;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;
    localparam logic [NLAGS_W-1:0] NLAGS_RESET = NLAGS_W'(16);

    typedef struct packed {
        logic accept;
        logic clear_taps;
        logic add;
        logic load;
        logic shift_out;
    } acr_ctl_t;

    function automatic logic [CNT_W-1:0] lag_count(input logic [NLAGS_W-1:0] n);
        logic [CNT_W-1:0] c;
        if (n == '0) begin
            c = CNT_W'(1);
        end else if (32'(n) > MAX_OUT) begin
            c = CNT_W'(MAX_OUT);
        end else begin
            c = CNT_W'(n);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/acr_cell.sv =====
// One lag cell: delay tap, registered product, saturating accumulator, drain register.
// Depends on acr_pkg.
`default_nettype none

module acr_cell
    import acr_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire acr_ctl_t                   ctl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [SAMPLE_W-1:0] tap_in,
    output logic signed [SAMPLE_W-1:0]      tap_out,
    input  wire logic        [ACC_W-1:0]    shadow_in,
    output logic             [ACC_W-1:0]    shadow_out
);

    logic signed [SAMPLE_W-1:0] tap_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic        [ACC_W-1:0]    shadow_reg;
    logic signed [ACC_W:0]      sum_wide;
    logic signed [ACC_W-1:0]    sum_sat;

    always_comb begin
        sum_wide = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(prod_reg);
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (ctl.accept) begin
                tap_reg <= ctl.clear_taps ? '0 : tap_in;
            end
            if (ctl.add) begin
                acc_reg <= ctl.load ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            prod_reg <= sample * tap_in;
        end
        if (ctl.add && ctl.load) begin
            shadow_reg <= sum_sat;
        end else if (ctl.shift_out) begin
            shadow_reg <= shadow_in;
        end
    end

    assign tap_out    = tap_reg;
    assign shadow_out = shadow_reg;

endmodule

`default_nettype wire

// ===== sv/block_autocorrelation.sv =====
// Block autocorrelation top level: handshakes, drain control and the row of lag cells.
// Depends on acr_pkg and acr_cell.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata = sample, s_tlast = last_sample
//  m_        out  m_tvalid/m_tready    m_tdata = lag_index, lag_value; m_tlast = last_result
//  cfg_      in   cfg_valid/cfg_ready  cfg_data = num_lags
//
// One sample per cycle: every cell multiplies in the accept cycle and accumulates in the
// next. On a last sample the sums move into a drain row and leave one beat per cycle while
// m_tready is high; the next block streams on, and only its last beat waits for the drain.
// Reset clears taps, sums and control; num_lags resets to 16.
`default_nettype none

module block_autocorrelation
    import acr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [15:0] sample
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // [3:0] lag_index, [51:4] lag_value
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [NLAGS_W-1:0]   cfg_data
);

    logic [NLAGS_W-1:0] num_lags_reg;
    logic               p_valid_reg;
    logic               p_last_reg;
    logic [CNT_W-1:0]   dump_cnt_reg;
    logic [CNT_W-1:0]   dump_cnt_next;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [IDX_W-1:0]   out_idx_next;
    logic               s_take;
    logic               m_take;
    logic               load;
    acr_ctl_t           ctl;

    logic signed [SAMPLE_W-1:0] taps    [0:MAX_LAGS];
    logic        [ACC_W-1:0]    shadows [0:MAX_LAGS];

    assign cfg_ready = 1'b1;
    assign s_tready  = !s_tlast || ((dump_cnt_reg == '0) && !(p_valid_reg && p_last_reg));
    assign s_take    = s_tvalid && s_tready;
    assign m_tvalid  = (dump_cnt_reg != '0);
    assign m_take    = m_tvalid && m_tready;
    assign load      = p_valid_reg && p_last_reg;

    always_comb begin
        ctl.accept     = s_take;
        ctl.clear_taps = s_tlast;
        ctl.add        = p_valid_reg;
        ctl.load       = p_last_reg;
        ctl.shift_out  = m_take;
    end

    always_comb begin
        dump_cnt_next = dump_cnt_reg;
        out_idx_next  = out_idx_reg;
        if (load) begin
            dump_cnt_next = lag_count(num_lags_reg);
            out_idx_next  = '0;
        end else if (m_take) begin
            dump_cnt_next = dump_cnt_reg - CNT_W'(1);
            out_idx_next  = out_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_lags_reg <= NLAGS_RESET;
            p_valid_reg  <= 1'b0;
            p_last_reg   <= 1'b0;
            dump_cnt_reg <= '0;
            out_idx_reg  <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_lags_reg <= cfg_data;
            end
            p_valid_reg  <= s_take;
            p_last_reg   <= s_take && s_tlast;
            dump_cnt_reg <= dump_cnt_next;
            out_idx_reg  <= out_idx_next;
        end
    end

    assign taps[0]           = signed'(s_tdata[SAMPLE_W-1:0]);
    assign shadows[MAX_LAGS] = '0;

    for (genvar k = 0; k < MAX_LAGS; k++) begin : g_cell
        acr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .sample     (taps[0]),
            .tap_in     (taps[k]),
            .tap_out    (taps[k+1]),
            .shadow_in  (shadows[k+1]),
            .shadow_out (shadows[k])
        );
    end

    assign m_tdata = {(M_TDATA_W-ACC_W-IDX_W)'(0), shadows[0], out_idx_reg};
    assign m_tlast = (dump_cnt_reg == CNT_W'(1));

    a_load_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (dump_cnt_reg == '0))
        else $error("sums loaded while drain row busy");

    a_drain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(dump_cnt_reg) <= MAX_OUT)
        else $error("drain count out of range");

    a_final_beat_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_take && m_tlast) |=> !m_tvalid)
        else $error("results continue after final beat");

    a_last_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && s_tlast) |=> !(s_tvalid && s_tready && s_tlast))
        else $error("two last beats taken back to back");

endmodule

`default_nettype wire
